// ===== hw/rtl/arpc_pkg.sv =====
// Package: shared types and constants for the ARP cache and responder.
`timescale 1ns / 1ps
package arpc_pkg;
	localparam int ENTRIES     = 64;
	localparam int IDX_BITS    = $clog2(ENTRIES);
	localparam int STAMP_BITS  = 32;
	localparam int MIN_ARP_LEN = 28;
	localparam logic [15:0] HW_ETHERNET = 16'd1;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_PACKET = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;
	// Register index, taken from paddr[3] since registers sit 8 bytes apart.
	localparam logic ADDR_OWN_IP  = 1'b0;
	localparam logic ADDR_OWN_MAC = 1'b1;
	localparam int ENTRY_BITS = 32 + 48 + STAMP_BITS;

	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] payload_len;
		logic [15:0] hw_type;
		logic [15:0] ptype;
		logic [15:0] opcode;
		logic [47:0] sender_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] lookup_ip;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic        send_reply;
		logic [47:0] reply_dest_mac;
		logic [31:0] reply_dest_ip;
		logic        found;
		logic [47:0] found_mac;
	} out_item_t;

	typedef struct packed {
		logic [31:0]           ip;
		logic [47:0]           mac;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic tick;       // advance the time stamp
		logic clr_scan;   // restart scan
		logic adv_scan;   // step scan index
		logic eval;       // evaluate returned entry
		logic wr;         // write back the chosen entry
		logic emit;       // drive the result strobe
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [1:0] kind;
		logic       reject;
		logic       scan_last;
	} sts_t;
endpackage

// ===== hw/rtl/arpc_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one word per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/arpc_datapath.sv =====
// Datapath: entry memory, valid bits, scan, replacement choice and result.
`timescale 1ns / 1ps
module arpc_datapath import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    item,
	input  logic [31:0] own_ip,
	input  logic        load,
	input  ctl_t        ctl,
	output sts_t        sts,
	output logic        done,
	output out_item_t   result
);
	in_item_t              item_q;
	logic [STAMP_BITS-1:0] now_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [IDX_BITS:0]     scan_q;
	logic [IDX_BITS-1:0]   eval_idx_q;
	logic                  hit_q;
	logic [IDX_BITS-1:0]   hit_idx_q;
	logic [47:0]           hit_mac_q;
	logic                  free_q;
	logic [IDX_BITS-1:0]   free_idx_q;
	logic [IDX_BITS-1:0]   old_idx_q;
	logic [STAMP_BITS-1:0] old_stamp_q;
	logic                  first_q;
	entry_t                rdata;
	entry_t                wdata;
	logic [IDX_BITS-1:0]   addr;
	logic [IDX_BITS-1:0]   wr_idx;
	logic [31:0]           key_ip;
	logic                  ent_valid;
	logic                  ent_match;
	out_item_t             res_d;

	assign key_ip    = (item_q.kind == KIND_LOOKUP) ? item_q.lookup_ip : item_q.src_ip;
	assign ent_valid = valid_q[eval_idx_q];
	assign ent_match = ent_valid && (rdata.ip == key_ip);
	assign wr_idx    = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
	assign addr      = ctl.wr ? wr_idx : scan_q[IDX_BITS-1:0];
	assign wdata     = '{ip: item_q.src_ip, mac: item_q.sender_mac, stamp: now_q};

	arpc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ctl.wr),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	assign sts.kind      = item_q.kind;
	assign sts.reject    = (item_q.payload_len < 11'(MIN_ARP_LEN))
		|| (item_q.hw_type != HW_ETHERNET) || (item_q.ptype != PROTO_IPV4);
	assign sts.scan_last = (scan_q == (IDX_BITS+1)'(ENTRIES));

	// Hold time stamp, valid bits, done strobe and the scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			valid_q <= '0;
			scan_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= ctl.emit;
			if (ctl.tick && (now_q != '1)) begin
				now_q <= now_q + 1'b1;
			end
			if (ctl.clr_scan) begin
				scan_q <= '0;
			end else if (ctl.adv_scan) begin
				scan_q <= scan_q + 1'b1;
			end
			if (ctl.wr) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	// Capture the transaction; track first match, first free entry and lowest-index oldest stamp.
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
		eval_idx_q <= scan_q[IDX_BITS-1:0];
		if (ctl.clr_scan) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			first_q <= 1'b1;
		end else if (ctl.eval) begin
			if (ent_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= eval_idx_q;
				hit_mac_q <= rdata.mac;
			end
			if (!ent_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= eval_idx_q;
			end
			if (ent_valid && (first_q || rdata.stamp < old_stamp_q)) begin
				old_idx_q   <= eval_idx_q;
				old_stamp_q <= rdata.stamp;
			end
			if (ent_valid) begin
				first_q <= 1'b0;
			end
		end
	end

	// Form the result of the transaction.
	always_comb begin
		res_d = '0;
		unique case (item_q.kind)
			KIND_PACKET: begin
				if (sts.reject) begin
					res_d.status = 1'b1;
				end else if (item_q.opcode == OP_REQUEST && item_q.dst_ip == own_ip) begin
					res_d.send_reply     = 1'b1;
					res_d.reply_dest_mac = item_q.sender_mac;
					res_d.reply_dest_ip  = item_q.src_ip;
				end
			end
			KIND_LOOKUP: begin
				res_d.found     = hit_q;
				res_d.found_mac = hit_q ? hit_mac_q : 48'd0;
			end
			default: begin
			end
		endcase
	end

	// Register the result of the transaction.
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result <= res_d;
		end
	end
endmodule

// ===== hw/rtl/arpc_ctrl.sv =====
// Controller: sequences load, scan, write-back and result.
`timescale 1ns / 1ps
module arpc_ctrl import arpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output logic load,
	output ctl_t ctl
);
	typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_DRAIN, S_WRITE, S_EMIT} state_t;
	state_t state_q;

	// Capture the transaction at the accepting edge.
	assign load = start && !busy;

	// Hold state and drive registered commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctl     <= '0;
			busy    <= 1'b0;
		end else begin
			ctl <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (load) begin
						ctl.clr_scan <= 1'b1;
						busy         <= 1'b1;
						state_q      <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (sts.kind == KIND_TICK) begin
						ctl.tick <= 1'b1;
						ctl.emit <= 1'b1;
						state_q  <= S_EMIT;
					end else if (sts.kind == KIND_LOOKUP
						|| (sts.kind == KIND_PACKET && !sts.reject)) begin
						ctl.adv_scan <= 1'b1;
						state_q      <= S_SCAN;
					end else begin
						ctl.emit <= 1'b1;
						state_q  <= S_EMIT;
					end
				end
				S_SCAN: begin
					ctl.eval <= 1'b1;
					if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end else begin
						ctl.adv_scan <= 1'b1;
					end
				end
				S_DRAIN: begin
					if (sts.kind == KIND_PACKET) begin
						ctl.wr  <= 1'b1;
						state_q <= S_WRITE;
					end else begin
						ctl.emit <= 1'b1;
						state_q  <= S_EMIT;
					end
				end
				S_WRITE: begin
					ctl.emit <= 1'b1;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/arp_cache_and_responder.sv =====
// Top level: APB registers, controller and datapath of the ARP cache.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy low; its single result
// appears on result for one cycle with done high and cannot be held off.
// Ticks, rejected packets and the unused kind go from decode straight to the
// result. Lookups and accepted packets first scan all 64 cache entries through
// the single port of the entry memory, one read a cycle; accepted packets then
// write back the chosen entry before the result. busy falls in the cycle that
// carries the result.
module arp_cache_and_responder import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic        load;
	ctl_t        ctl;
	sts_t        sts;

	assign pready = 1'b1;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				ADDR_OWN_IP:  own_ip_q  <= pwdata[31:0];
				ADDR_OWN_MAC: own_mac_q <= pwdata[47:0];
			endcase
		end
	end

	// Read back configuration registers.
	always_comb begin
		unique case (paddr[3])
			ADDR_OWN_IP:  prdata = {32'd0, own_ip_q};
			ADDR_OWN_MAC: prdata = {16'd0, own_mac_q};
		endcase
	end

	arpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.load   (load),
		.ctl    (ctl)
	);

	arpc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.own_ip (own_ip_q),
		.load   (load),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);
endmodule

// ===== hw/rtl/arpc_checker.sv =====
// Checker: port-level properties of the ARP cache, bound to the top level.
`timescale 1ns / 1ps
module arpc_checker import arpc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t result
);
	// A result only leaves at the end of a transaction in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without transaction");
	// An accepted transaction raises busy.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");
	// Results are single-cycle strobes.
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than a cycle");
	// A reject never comes with a reply or a hit.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (!result.send_reply && !result.found))
		else $error("reject mixed with other result");
endmodule

bind arp_cache_and_responder arpc_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== tb/tb_arp_cache_and_responder.sv =====
// Testbench: directed table and random ARP traffic against a cache and responder predictor.
`timescale 1ns / 1ps
module tb_arp_cache_and_responder;
	import arpc_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 1530;
	localparam logic [3:0] REG_OWN_IP = 4'd0;
	localparam logic [3:0] REG_OWN_MAC = 4'd8;
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam logic [31:0] IP_POOL_BASE = 32'h0A00_0000;

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t ex;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    item = '0;
	logic        done;
	out_item_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	// shadow of the cache and registers
	logic [31:0] cache_ip [ENTRIES];
	logic [47:0] cache_mac [ENTRIES];
	logic [STAMP_BITS-1:0] cache_stamp [ENTRIES];
	bit          cache_valid [ENTRIES];
	logic [STAMP_BITS-1:0] now_stamp;
	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;

	out_item_t   pending_results[$];
	out_item_t   typed_result;
	bit          typed_armed = 1'b0;
	int          mismatches = 0;
	int          cycles = 0;
	int          sender_idle_pct = 0;
	int          n_items = 0;
	int          n_replies = 0;
	int          n_hits = 0;
	int          n_rejects = 0;
	vector_t     directed[$];

	arp_cache_and_responder dut (.*);

	always #6 clk = ~clk;

	// learn a sender: refresh its entry or take a free or the oldest slot
	function automatic void learn_sender(logic [31:0] ip, logic [47:0] mac);
		int victim;
		victim = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (cache_valid[i] && cache_ip[i] == ip) begin
				cache_mac[i] = mac;
				cache_stamp[i] = now_stamp;
				return;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (!cache_valid[i]) begin
				victim = i;
				break;
			end
			if (cache_stamp[i] < cache_stamp[victim])
				victim = i;
		end
		cache_ip[victim] = ip;
		cache_mac[victim] = mac;
		cache_stamp[victim] = now_stamp;
		cache_valid[victim] = 1'b1;
	endfunction

	// compute the response to one transaction and advance the shadow state
	function automatic out_item_t arp_response(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.kind)
			KIND_TICK: begin
				if (now_stamp != '1)
					now_stamp = now_stamp + 1'b1;
			end
			KIND_PACKET: begin
				if (it.payload_len < MIN_ARP_LEN || it.hw_type != HW_ETHERNET ||
				    it.ptype != PROTO_IPV4) begin
					r.status = 1'b1;
				end else begin
					learn_sender(it.src_ip, it.sender_mac);
					if (it.opcode == OP_REQUEST && it.dst_ip == own_ip_q) begin
						r.send_reply = 1'b1;
						r.reply_dest_mac = it.sender_mac;
						r.reply_dest_ip = it.src_ip;
					end
				end
			end
			KIND_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (cache_valid[i] && cache_ip[i] == it.lookup_ip) begin
						r.found = 1'b1;
						r.found_mac = cache_mac[i];
						break;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [47:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	function automatic logic [31:0] pool_ip();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return IP_POOL_BASE | $urandom_range(0, 95);
	endfunction

	// mostly well-formed packets over a small address pool, some noise
	function automatic in_item_t random_item();
		in_item_t it;
		logic [223:0] raw;
		int sel;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			it.kind = KIND_TICK;
		end else if (sel < 30) begin
			it.kind = KIND_LOOKUP;
			it.lookup_ip = ($urandom_range(0, 1) == 0) ? own_ip_q : pool_ip();
			if ($urandom_range(0, 3) != 0)
				it.lookup_ip = pool_ip();
		end else if (sel < 88) begin
			it.kind = KIND_PACKET;
			it.payload_len = 11'($urandom_range(MIN_ARP_LEN, 2047));
			it.hw_type = HW_ETHERNET;
			it.ptype = PROTO_IPV4;
			case ($urandom_range(0, 3))
				0, 1: it.opcode = OP_REQUEST;
				2: it.opcode = 16'd2;
				default: ;
			endcase
			it.sender_mac = rand_mac();
			it.src_ip = pool_ip();
			if ($urandom_range(0, 1) == 0)
				it.dst_ip = own_ip_q;
		end else if (sel < 96) begin
			it.kind = KIND_PACKET;
			case ($urandom_range(0, 2))
				0: it.payload_len = 11'($urandom_range(0, MIN_ARP_LEN - 1));
				1: it.hw_type = 16'($urandom_range(2, 65535));
				default: it.ptype = 16'($urandom_range(0, 16'h07FF));
			endcase
		end
		return it;
	endfunction

	function automatic in_item_t mk(logic [1:0] kind, logic [10:0] len, logic [15:0] hw,
			logic [15:0] pt, logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
			logic [31:0] tip, logic [31:0] lip);
		in_item_t it;
		it = '{kind, len, hw, pt, op, smac, sip, tip, lip};
		return it;
	endfunction

	function automatic void add_row(in_item_t it, bit typed, out_item_t ex);
		vector_t v;
		v.it = it;
		v.typed = typed;
		v.ex = ex;
		directed.push_back(v);
	endfunction

	// record accepted transactions, check each result against the oldest expectation
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && done) begin
			got = result;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no transaction outstanding: %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.send_reply !== want.send_reply ||
				    got.reply_dest_mac !== want.reply_dest_mac ||
				    got.reply_dest_ip !== want.reply_dest_ip ||
				    got.found !== want.found || got.found_mac !== want.found_mac) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st%b rp%b %h %h f%b %h got st%b rp%b %h %h f%b %h",
							want.status, want.send_reply, want.reply_dest_mac,
							want.reply_dest_ip, want.found, want.found_mac,
							got.status, got.send_reply, got.reply_dest_mac,
							got.reply_dest_ip, got.found, got.found_mac);
				end
			end
		end
		if (arst_n && start && !busy) begin
			want = arp_response(item);
			if (want.send_reply) n_replies++;
			if (want.found) n_hits++;
			if (want.status) n_rejects++;
			pending_results.push_back(typed_armed ? typed_result : want);
			n_items++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// drive one transaction, optionally after a random gap, hold until taken
	task automatic send(in_item_t it, bit typed, out_item_t ex);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		typed_armed <= typed;
		typed_result <= ex;
		do @(posedge clk); while (busy);
	endtask

	// wait for the block to go quiet before touching the registers
	task automatic settle();
		start <= 1'b0;
		typed_armed <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [3:0] addr, logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_OWN_IP)
			own_ip_q = data[31:0];
		else if (addr == REG_OWN_MAC)
			own_mac_q = data[47:0];
	endtask

	initial begin
		out_item_t z;
		out_item_t e;
		for (int i = 0; i < ENTRIES; i++) begin
			cache_valid[i] = 1'b0;
			cache_ip[i] = '0;
			cache_mac[i] = '0;
			cache_stamp[i] = '0;
		end
		now_stamp = '0;
		own_ip_q = '0;
		own_mac_q = '0;
		z = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(REG_OWN_IP, 64'hC0A8_0001);
		reg_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);

		// directed: empty cache, rejects, no-op, learn, reply, refresh
		add_row(mk(KIND_TICK, '1, '1, '1, '1, '1, '1, '1, '1), 1, z);
		add_row(mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 32'h0A00_0001), 1, z);
		add_row(mk(KIND_NOP, '1, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1, '1, '1, '1), 1, z);
		e = z;
		e.status = 1'b1;
		add_row(mk(KIND_PACKET, 27, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 1, 1, 32'hC0A8_0001, 0),
			1, e);
		add_row(mk(KIND_PACKET, 0, 0, PROTO_IPV4, OP_REQUEST, 1, 1, 0, 0), 1, e);
		add_row(mk(KIND_PACKET, 28, HW_ETHERNET, 16'h86DD, OP_REQUEST, 1, 1, 0, 0), 1, e);
		add_row(mk(KIND_PACKET, '1, '1, '1, '1, '1, '1, '1, '1), 1, e);
		e = z;
		e.send_reply = 1'b1;
		e.reply_dest_mac = 48'hFFFF_FFFF_FFFF;
		e.reply_dest_ip = 32'h0A00_0001;
		add_row(mk(KIND_PACKET, 28, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1, 32'h0A00_0001,
			32'hC0A8_0001, 0), 1, e);
		e = z;
		e.found = 1'b1;
		e.found_mac = 48'hFFFF_FFFF_FFFF;
		add_row(mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 32'h0A00_0001), 1, e);
		add_row(mk(KIND_PACKET, 2047, HW_ETHERNET, PROTO_IPV4, 16'd2, 0, 32'h0A00_0001,
			32'hC0A8_0001, 0), 1, z);
		e.found_mac = '0;
		add_row(mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 32'h0A00_0001), 1, e);
		add_row(mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(KIND_PACKET, 100, HW_ETHERNET, PROTO_IPV4, '1, 48'h0123_4567_89AB, '1, 0, 0),
			0, z);
		add_row(mk(KIND_PACKET, 64, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'hA5A5_5A5A_A5A5,
			0, 32'hC0A8_0002, 0), 1, z);
		add_row(mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, '1), 0, z);
		add_row(mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 32'h0A00_0002), 1, z);
		foreach (directed[i])
			send(directed[i].it, directed[i].typed, directed[i].ex);
		settle();

		// random phases: sender idles sometimes, then often, then not at all
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 32;
					reg_write(REG_OWN_IP, 64'hFFFF_FFFF);
					reg_write(REG_OWN_MAC, 64'h0);
				end
				1: begin
					sender_idle_pct = 79;
					reg_write(REG_OWN_IP, 64'h0);
					reg_write(REG_OWN_MAC, 64'h0000_0123_4567_89AB);
				end
				default: begin
					sender_idle_pct = 0;
					reg_write(REG_OWN_IP, {32'd0, IP_POOL_BASE | 32'd7});
					reg_write(REG_OWN_MAC, {$urandom, $urandom});
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 3; n++)
				send(random_item(), 0, z);
			settle();
		end

		$display("%0d transactions: %0d replies, %0d lookup hits, %0d rejects",
			n_items, n_replies, n_hits, n_rejects);
		$display("own address registers at both extremes; cache churned past %0d entries",
			ENTRIES);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				pending_results.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_ram.sv
hw/rtl/arpc_datapath.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arp_cache_and_responder.sv
hw/rtl/arpc_checker.sv
tb/tb_arp_cache_and_responder.sv
